/* design/xtea_pkg.sv */
// shared constants and register codes for the xtea block cipher
`timescale 1ns / 1ps

package xtea_pkg;

    // cipher constants
    localparam logic [31:0] XT_DELTA   = 32'h9E3779B9;
    localparam int unsigned XT_SHL     = 4;
    localparam int unsigned XT_SHR     = 5;
    localparam int unsigned XT_SUM_SEL = 11;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY0      = 3'd0;
    localparam logic [2:0] CFG_KEY1      = 3'd1;
    localparam logic [2:0] CFG_KEY2      = 3'd2;
    localparam logic [2:0] CFG_KEY3      = 3'd3;
    localparam logic [2:0] CFG_ROUNDS    = 3'd4;
    localparam logic [2:0] CFG_DIRECTION = 3'd5;

    // reset values
    localparam logic [7:0] ROUNDS_RESET = 8'd16;

    // operands of one half round
    typedef struct packed {
        logic [31:0] mix_src;
        logic [31:0] acc;
        logic [31:0] sum;
        logic [31:0] key;
        logic        sub;
    } t_half_in;

endpackage

/* design/xtea_half.sv */
// one xtea half round: acc +/- (mix(src) ^ (sum + key))
`timescale 1ns / 1ps

module xtea_half
    import xtea_pkg::*;
(
    input  t_half_in    i_op,
    output logic [31:0] o_acc
);

    logic [31:0] mix_val;
    logic [31:0] sum_key;
    logic [31:0] term;

    // word mix ignores the running sum
    assign mix_val = ((i_op.mix_src << XT_SHL) ^ (i_op.mix_src >> XT_SHR)) + i_op.mix_src;
    assign sum_key = i_op.sum + i_op.key;
    assign term    = mix_val ^ sum_key;

    // encipher adds, decipher subtracts
    assign o_acc = i_op.sub ? (i_op.acc - term) : (i_op.acc + term);

endmodule

/* design/xtea_block_cipher.sv */
// xtea block cipher top level: config registers, sequencer and output register
//
// channel   dir   handshake                 word
// s_axis    in    i_s_tvalid / o_s_tready   64-bit block in
// m_axis    out   o_m_tvalid / i_m_tready   64-bit block out
// cfg       in    i_cfg_valid / o_cfg_ready register index and 32-bit data
//
// a block runs one half round per cycle through the shared round unit, two half
// rounds per round, then waits in the done state until the output register is free.
// with round_count zero the block skips the rounds and comes out unchanged.
// the input is not ready while a block is in work or waits for the output.
// reset clears the key to zero, rounds to 16 and direction to encipher.
`timescale 1ns / 1ps

module xtea_block_cipher
    import xtea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: [31:0] word_first, [63:32] word_second
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,
    // master side: [31:0] out_first, [63:32] out_second
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [31:0] r_key [4];
    logic [7:0]  r_rounds;
    logic        r_dir;

    logic [1:0]  r_state, n_state;
    logic        r_phase, n_phase;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_y, n_y;
    logic [31:0] r_z, n_z;
    logic [31:0] r_sum, n_sum;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out, n_out;

    logic        s_acc;
    logic        tgt_y;
    logic [1:0]  key_sel;
    t_half_in    half_op;
    logic [31:0] half_res;
    logic [31:0] sum_init;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= '0;
            r_key[1] <= '0;
            r_key[2] <= '0;
            r_key[3] <= '0;
            r_rounds <= ROUNDS_RESET;
            r_dir    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KEY0:      r_key[0] <= i_cfg_data;
                CFG_KEY1:      r_key[1] <= i_cfg_data;
                CFG_KEY2:      r_key[2] <= i_cfg_data;
                CFG_KEY3:      r_key[3] <= i_cfg_data;
                CFG_ROUNDS:    r_rounds <= i_cfg_data[7:0];
                CFG_DIRECTION: r_dir    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // half round operand selection
    assign tgt_y   = (r_phase == r_dir);
    assign key_sel = tgt_y ? r_sum[1:0] : r_sum[XT_SUM_SEL+1:XT_SUM_SEL];

    always_comb begin
        half_op.mix_src = tgt_y ? r_z : r_y;
        half_op.acc     = tgt_y ? r_y : r_z;
        half_op.sum     = r_sum;
        half_op.key     = r_key[key_sel];
        half_op.sub     = r_dir;
    end

    xtea_half u_half (
        .i_op  (half_op),
        .o_acc (half_res)
    );

    // decipher starts the sum at delta times the round count
    assign sum_init = r_dir ? 32'(XT_DELTA * {24'd0, r_rounds}) : 32'd0;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_left      = r_left;
        n_y         = r_y;
        n_z         = r_z;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_y     = i_s_tdata[31:0];
                    n_z     = i_s_tdata[63:32];
                    n_sum   = sum_init;
                    n_phase = 1'b0;
                    n_left  = r_rounds;
                    n_state = (r_rounds == 8'd0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                if (tgt_y) begin
                    n_y = half_res;
                end else begin
                    n_z = half_res;
                end
                if (!r_phase) begin
                    n_sum = r_dir ? (r_sum - XT_DELTA) : (r_sum + XT_DELTA);
                end else begin
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_state = ST_DONE;
                    end
                end
                n_phase = !r_phase;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = {r_z, r_y};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_left  <= n_left;
        r_y     <= n_y;
        r_z     <= n_z;
        r_sum   <= n_sum;
        r_out   <= n_out;
    end

    // checks
    a_run_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_left != 8'd0))
        else $error("round counter empty while running");

    a_zero_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (r_rounds == 8'd0)) |=> (r_state == ST_DONE))
        else $error("zero round block did not bypass the rounds");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result shown without a finished block");

    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && r_phase && (r_left == 8'd1)) |=> (r_state == ST_DONE))
        else $error("sequencer missed the last round");

endmodule
